### rtl/bpc_pkg.sv
// Shared types and constants for the byte pattern counter.
package bpc_pkg;

	localparam int DATA_W        = 8;
	localparam int LEN_W         = 4;
	localparam int CNT_W         = 16;
	localparam int PAT_W         = 64;
	localparam int CFG_IDX_W     = 1;
	localparam int OUT_TDATA_W   = 56;

	localparam int MAX_PATTERN_DEF  = 8;
	localparam int MAX_SEQUENCE_DEF = 65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

	typedef struct packed {
		logic             match_here;
		logic [CNT_W-1:0] match_start;
		logic [CNT_W-1:0] match_count;
		logic             found_any;
		logic [CNT_W-1:0] first_index;
		logic             prefix_match;
		logic             suffix_match;
		logic             sequence_end;
	} result_t;

endpackage

### rtl/bpc_cell.sv
// One window cell: holds one recent byte and compares its incoming byte.
module bpc_cell (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [bpc_pkg::DATA_W-1:0] din,
	input  logic [bpc_pkg::DATA_W-1:0] pattern_byte,
	input  logic                       active,
	output logic [bpc_pkg::DATA_W-1:0] dout,
	output logic                       hit
);

	logic [bpc_pkg::DATA_W-1:0] byte_q;

	// window content is only trusted once enough bytes of a sequence arrived
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	// inactive cells lie beyond the separator length and always agree
	assign hit  = !active || (din == pattern_byte);

endmodule

### rtl/bpc_tracker.sv
// Per-sequence tracking: position, overlap blocking, counts and flags.
module bpc_tracker #(
	parameter int MAX_PATTERN  = bpc_pkg::MAX_PATTERN_DEF,
	parameter int MAX_SEQUENCE = bpc_pkg::MAX_SEQUENCE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      window_hit,
	input  logic [bpc_pkg::LEN_W-1:0] len,
	input  logic                      last,
	output bpc_pkg::result_t          result
);

	localparam int POS_W = $clog2(MAX_SEQUENCE + 1);
	localparam int BLK_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int EXT_W = (POS_W > bpc_pkg::CNT_W) ? POS_W : bpc_pkg::CNT_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SEQUENCE);

	logic [POS_W-1:0]          position_q;
	logic [BLK_W-1:0]          block_q, block_d;
	logic [bpc_pkg::CNT_W-1:0] count_q, count_d;
	logic [bpc_pkg::CNT_W-1:0] first_q, first_d;
	logic                      seen_q, seen_d;
	logic                      prefix_q, prefix_d;

	logic [bpc_pkg::LEN_W-1:0] len_m1;
	logic [POS_W-1:0]          len_m1_ext;
	logic [POS_W-1:0]          start;
	logic [EXT_W-1:0]          start_ext;
	logic [bpc_pkg::CNT_W-1:0] start_sat;
	logic                      raw;
	logic                      counted;

	assign len_m1     = len - bpc_pkg::LEN_W'(1);
	assign len_m1_ext = POS_W'(len_m1);
	assign raw        = window_hit && (len != '0) && (position_q >= len_m1_ext);
	assign start      = position_q - len_m1_ext;
	assign start_ext  = EXT_W'(start);
	assign start_sat  = (start_ext > EXT_W'({bpc_pkg::CNT_W{1'b1}})) ?
		'1 : start_ext[bpc_pkg::CNT_W-1:0];

	always_comb begin
		counted = 1'b0;
		block_d = block_q;
		if (block_q != '0) begin
			block_d = block_q - BLK_W'(1);
		end else if (raw) begin
			counted = 1'b1;
			block_d = len_m1[BLK_W-1:0];
		end
		count_d  = (counted && (count_q != '1)) ? count_q + bpc_pkg::CNT_W'(1) : count_q;
		seen_d   = seen_q || counted;
		first_d  = (counted && !seen_q) ? start_sat : first_q;
		prefix_d = prefix_q || (raw && (position_q == len_m1_ext));
	end

	always_comb begin
		result.match_here   = counted;
		result.match_start  = counted ? start_sat : '0;
		result.match_count  = count_d;
		result.found_any    = seen_d;
		result.first_index  = seen_d ? first_d : '0;
		result.prefix_match = prefix_d;
		result.suffix_match = last && raw;
		result.sequence_end = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			block_q    <= '0;
			count_q    <= '0;
			first_q    <= '0;
			seen_q     <= 1'b0;
			prefix_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				block_q    <= '0;
				count_q    <= '0;
				first_q    <= '0;
				seen_q     <= 1'b0;
				prefix_q   <= 1'b0;
			end else begin
				if (position_q < POS_MAX) begin
					position_q <= position_q + POS_W'(1);
				end
				block_q  <= block_d;
				count_q  <= count_d;
				first_q  <= first_d;
				seen_q   <= seen_d;
				prefix_q <= prefix_d;
			end
		end
	end

endmodule

### rtl/byte_pattern_counter_core.sv
// Byte pattern counter: streams bytes through a window and counts separator hits.
//
// Each accepted byte shifts into a row of MAX_PATTERN window cells; every cell
// compares the byte it takes in against its separator byte, so the full window
// compare is done in the cycle the item is accepted. A tracker then applies
// leftmost non-overlapping counting (after a counted hit, no hit may end in the
// next length-1 bytes), records the first start index and the prefix flag, and
// on the item marked tlast reports the suffix flag and restarts the sequence.
// Exactly one result item leaves per input item, in the cycle after acceptance;
// the block takes one item per cycle, limited only by the single output
// register, which stalls input just when it is full and not being drained.
// Start indices and the count saturate at 65535; a length of 0 never matches,
// one above MAX_PATTERN acts as MAX_PATTERN. Configuration (separator bytes at
// index 0, length at index 1) must be written only while idle (not enforced).
module byte_pattern_counter_core #(
	parameter int MAX_PATTERN  = bpc_pkg::MAX_PATTERN_DEF,
	parameter int MAX_SEQUENCE = bpc_pkg::MAX_SEQUENCE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::PAT_W-1:0]         cfg_data,
	// byte input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bpc_pkg::DATA_W-1:0]        s_axis_tdata,  // [7:0] data_byte
	input  logic                              s_axis_tlast,  // last_byte
	// result output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] match_here, [16:1] match_start, [32:17] match_count, [33] found_any,
	// [49:34] first_index, [50] prefix_match, [51] suffix_match, [55:52] zero
	output logic [bpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast   // sequence_end
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [bpc_pkg::PAT_W-1:0] pattern_bytes_q;
	logic [bpc_pkg::LEN_W-1:0] pattern_length_q;
	logic [bpc_pkg::LEN_W-1:0] eff_len;

	logic                      in_accept;
	logic [bpc_pkg::DATA_W-1:0] cell_din [MAX_PATTERN];
	logic [bpc_pkg::DATA_W-1:0] cell_dout [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]     cell_hit;

	bpc_pkg::result_t result;
	bpc_pkg::result_t out_q;
	logic             out_valid_q;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_length_q <= bpc_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpc_pkg::REG_PATTERN_BYTES:  pattern_bytes_q  <= cfg_data;
				bpc_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[bpc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_len = (pattern_length_q > bpc_pkg::LEN_W'(MAX_PATTERN)) ?
		bpc_pkg::LEN_W'(MAX_PATTERN) : pattern_length_q;

	// input is taken whenever the output register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// window chain: cell 0 takes the new byte, cell j the byte j items back
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [bpc_pkg::LEN_W-1:0] k_full;
		logic [IDX_W-1:0]          k;
		logic                      active;

		if (j == 0) begin : g_head
			assign cell_din[j] = s_axis_tdata;
		end else begin : g_link
			assign cell_din[j] = cell_dout[j-1];
		end

		// cell j meets separator byte length-1-j
		assign active = bpc_pkg::LEN_W'(j) < eff_len;
		assign k_full = eff_len - bpc_pkg::LEN_W'(1) - bpc_pkg::LEN_W'(j);
		assign k      = k_full[IDX_W-1:0];

		bpc_cell u_cell (
			.clk          (clk),
			.shift_en     (in_accept),
			.din          (cell_din[j]),
			.pattern_byte (pattern_bytes_q[bpc_pkg::DATA_W*k +: bpc_pkg::DATA_W]),
			.active       (active),
			.dout         (cell_dout[j]),
			.hit          (cell_hit[j])
		);
	end

	bpc_tracker #(
		.MAX_PATTERN  (MAX_PATTERN),
		.MAX_SEQUENCE (MAX_SEQUENCE)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_accept),
		.window_hit (&cell_hit),
		.len        (eff_len),
		.last       (s_axis_tlast),
		.result     (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.sequence_end;
	assign m_axis_tdata  = {4'b0000,
		out_q.suffix_match,
		out_q.prefix_match,
		out_q.first_index,
		out_q.found_any,
		out_q.match_count,
		out_q.match_start,
		out_q.match_here};

endmodule

### rtl/bpc_checker.sv
// Port-level checks for the byte pattern counter, bound to the top level.
module bpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// empty output register never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a counted hit implies found_any and a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[33] && (m_axis_tdata[32:17] != '0))
		else $error("hit without count or found flag");

	// suffix flag only on the final item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[51] |-> m_axis_tlast)
		else $error("suffix flag off sequence end");

endmodule

bind byte_pattern_counter_core bpc_checker u_bpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
